FILE: rtl/core/date_difference_days_core_macros.svh
// Assertion macros for the date difference core.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef DATE_DIFFERENCE_DAYS_CORE_MACROS_SVH
`define DATE_DIFFERENCE_DAYS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DDD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("date difference core: check failed");

// next-cycle implication
`define DDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("date difference core: check failed");

`else

`define DDD_ASSERT_NOW(label, clk, rst, ante, cons)
`define DDD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/ddd_pkg.sv
// Shared types, constants and calendar tables for the date difference core.
// No dependencies; compiled first after the macro header.
`default_nettype none

package ddd_pkg;

   localparam int DAY_W         = 5;
   localparam int MONTH_W       = 4;
   localparam int GAP_W         = 23;
   localparam int YEAR_BITS_DEF = 14;

   localparam logic [GAP_W-1:0] GAP_MAX = '1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FIRST_BAD  = 2'd1,
      STATUS_SECOND_BAD = 2'd2
   } status_type;

   // one finished result item
   typedef struct packed {
      status_type       status;
      logic [GAP_W-1:0] day_gap;
   } rsp_item_type;

   // days before the month in a common year; zero for codes that are no month
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
      logic [8:0] days;
      unique case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // days in the month in a common year; zero for codes that are no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] days;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
         4'd2:                                       days = 5'd28;
         default:                                    days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ddd_if.sv
// Request and response channel interfaces for the date difference core.
// Depends on ddd_pkg for field widths and the status type.
`default_nettype none

// request channel: one pair of dates per item
interface ddd_req_if import ddd_pkg::*; #(
   parameter int YEAR_BITS = YEAR_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic [DAY_W-1:0]     first_day;
   logic [MONTH_W-1:0]   first_month;
   logic [YEAR_BITS-1:0] first_year;
   logic [DAY_W-1:0]     second_day;
   logic [MONTH_W-1:0]   second_month;
   logic [YEAR_BITS-1:0] second_year;

   modport source (
      output valid, first_day, first_month, first_year,
      output second_day, second_month, second_year,
      input  ready
   );
   modport sink (
      input  valid, first_day, first_month, first_year,
      input  second_day, second_month, second_year,
      output ready
   );
endinterface

// response channel: status and day gap per item
interface ddd_rsp_if import ddd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [GAP_W-1:0] day_gap;

   modport source (output valid, status, day_gap, input ready);
   modport sink (input valid, status, day_gap, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ddd_lane.sv
// One date lane: checks a date and turns it into a day count (Jan 1, year 1 = 1).
// Four register stages, all moving on advance. Depends on ddd_pkg.
`default_nettype none

module ddd_lane import ddd_pkg::*; #(
   parameter int YEAR_BITS = YEAR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [DAY_W-1:0]       day,
   input  logic [MONTH_W-1:0]     month,
   input  logic [YEAR_BITS-1:0]   year,
   output logic [YEAR_BITS+8:0]   day_num,
   output logic                   date_ok
);

   localparam int DAY_BITS    = YEAR_BITS + 9;
   localparam int Q_BITS      = YEAR_BITS - 2;
   // divide by 25 as multiply by a rounded-up reciprocal
   localparam int RECIP_SHIFT = Q_BITS + 5;
   localparam int RECIP_W     = RECIP_SHIFT - 4;
   localparam int PROD_W      = Q_BITS + RECIP_W;
   localparam int Q100_W      = YEAR_BITS - 6;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / 25 + 1);

   // stage 1: previous year and (p / 4) * recip
   logic [YEAR_BITS-1:0] s1_p_in, s1_p_ff;
   logic [PROD_W-1:0]    s1_prod_in, s1_prod_ff;
   logic [DAY_W-1:0]     s1_day_ff;
   logic [MONTH_W-1:0]   s1_month_ff;
   logic                 s1_yzero_in, s1_yzero_ff;

   always_comb begin
      s1_p_in     = year - YEAR_BITS'(1);
      s1_prod_in  = PROD_W'(s1_p_in[YEAR_BITS-1:2]) * PROD_W'(RECIP);
      s1_yzero_in = (year == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_p_ff     <= s1_p_in;
         s1_prod_ff  <= s1_prod_in;
         s1_day_ff   <= day;
         s1_month_ff <= month;
         s1_yzero_ff <= s1_yzero_in;
      end
   end

   // stage 2: p / 100 and p % 100
   logic [Q100_W-1:0]    s2_q100_in, s2_q100_ff;
   logic [YEAR_BITS-1:0] s2_rem_full;
   logic [6:0]           s2_r100_in, s2_r100_ff;
   logic [YEAR_BITS-1:0] s2_p_ff;
   logic [DAY_W-1:0]     s2_day_ff;
   logic [MONTH_W-1:0]   s2_month_ff;
   logic                 s2_yzero_ff;

   always_comb begin
      s2_q100_in  = s1_prod_ff[RECIP_SHIFT +: Q100_W];
      s2_rem_full = s1_p_ff - YEAR_BITS'(s2_q100_in) * YEAR_BITS'(100);
      s2_r100_in  = s2_rem_full[6:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_q100_ff  <= s2_q100_in;
         s2_r100_ff  <= s2_r100_in;
         s2_p_ff     <= s1_p_ff;
         s2_day_ff   <= s1_day_ff;
         s2_month_ff <= s1_month_ff;
         s2_yzero_ff <= s1_yzero_ff;
      end
   end

   // stage 3: leap year, validity, and the three partial sums
   logic                 s3_leap;
   logic [DAY_W-1:0]     s3_limit;
   logic [Q_BITS-1:0]    s3_q4;
   logic [DAY_BITS-1:0]  s3_years_in, s3_years_ff;
   logic [Q_BITS-1:0]    s3_corr_in, s3_corr_ff;
   logic [8:0]           s3_mdays_in, s3_mdays_ff;
   logic                 s3_ok_in, s3_ok_ff;

   always_comb begin
      // y = p + 1: y % 4 == 0 when p % 4 == 3, y % 100 == 0 when p % 100 == 99
      s3_leap = (s2_p_ff[1:0] == 2'b11) &&
                ((s2_r100_ff != 7'd99) || (s2_q100_ff[1:0] == 2'b11));
      s3_limit = month_len(s2_month_ff);
      if ((s2_month_ff == MONTH_W'(2)) && s3_leap) begin
         s3_limit = DAY_W'(29);
      end
      s3_ok_in = !s2_yzero_ff &&
                 (s2_month_ff >= MONTH_W'(1)) && (s2_month_ff <= MONTH_W'(12)) &&
                 (s2_day_ff >= DAY_W'(1)) && (s2_day_ff <= s3_limit);
      s3_q4       = s2_p_ff[YEAR_BITS-1:2];
      s3_years_in = DAY_BITS'(s2_p_ff) * DAY_BITS'(365);
      s3_corr_in  = s3_q4 - Q_BITS'(s2_q100_ff) + Q_BITS'(s2_q100_ff >> 2);
      s3_mdays_in = month_start(s2_month_ff) +
                    9'((s2_month_ff > MONTH_W'(2)) && s3_leap) +
                    9'(s2_day_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_years_ff <= s3_years_in;
         s3_corr_ff  <= s3_corr_in;
         s3_mdays_ff <= s3_mdays_in;
         s3_ok_ff    <= s3_ok_in;
      end
   end

   // stage 4: final day count
   logic [DAY_BITS-1:0] s4_num_in, s4_num_ff;
   logic                s4_ok_ff;

   assign s4_num_in = s3_years_ff + DAY_BITS'(s3_corr_ff) + DAY_BITS'(s3_mdays_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_num_ff <= s4_num_in;
         s4_ok_ff  <= s3_ok_ff;
      end
   end

   assign day_num = s4_num_ff;
   assign date_ok = s4_ok_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ddd_merge.sv
// Merge stage: combines the two lane results into status and saturated gap.
// One register stage moving on advance. Depends on ddd_pkg.
`default_nettype none

module ddd_merge import ddd_pkg::*; #(
   parameter int YEAR_BITS = YEAR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [YEAR_BITS+8:0] first_num,
   input  logic                 first_ok,
   input  logic [YEAR_BITS+8:0] second_num,
   input  logic                 second_ok,
   output rsp_item_type         item
);

   localparam int DAY_BITS = YEAR_BITS + 9;
   localparam int CALC_W   = (DAY_BITS > GAP_W) ? DAY_BITS : GAP_W;

   logic [CALC_W-1:0] num_a, num_b, diff;
   logic [GAP_W-1:0]  gap;
   rsp_item_type      item_in, item_ff;

   // absolute difference, clipped to the output width
   always_comb begin
      num_a = CALC_W'(first_num);
      num_b = CALC_W'(second_num);
      diff  = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);
      gap   = (diff > CALC_W'(GAP_MAX)) ? GAP_MAX : diff[GAP_W-1:0];
   end

   // first date is checked first
   always_comb begin
      priority if (!first_ok) begin
         item_in.status  = STATUS_FIRST_BAD;
         item_in.day_gap = '0;
      end else if (!second_ok) begin
         item_in.status  = STATUS_SECOND_BAD;
         item_in.day_gap = '0;
      end else begin
         item_in.status  = STATUS_OK;
         item_in.day_gap = gap;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ddd_out_buf.sv
// Two-entry output buffer (output register plus skid entry).
// Room is registered, so the pipeline never sees the receiver's ready. Depends on ddd_pkg.
`default_nettype none

module ddd_out_buf import ddd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         out_valid_in, out_valid_ff;
   logic         skid_valid_in, skid_valid_ff;
   rsp_item_type out_item_in, out_item_ff;
   rsp_item_type skid_item_in, skid_item_ff;
   logic         pop;

   assign pop = out_valid_ff && out_ready;

   // next state of both entries
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      priority if (!out_valid_ff) begin
         out_valid_in = push;
         out_item_in  = push_item;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = push;
            skid_item_in  = push_item;
         end else begin
            out_valid_in = push;
            out_item_in  = push_item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign room      = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

`default_nettype wire

FILE: rtl/core/date_difference_days_core.sv
// Date difference core: absolute day count between two Gregorian dates.
// Request channel req_in carries two (day, month, year) dates per item; response
// channel rsp_out carries a status (both valid, first bad, second bad) and the gap.
// Both use valid/ready; an item moves at a clock edge where both are high.
// Two identical lanes, one per date, check the date and build its day count in
// four register stages; a merge stage forms status and |difference|, and a
// two-entry output buffer holds finished items.
// Throughput: one item per cycle, sustained while rsp_out.ready stays high.
// Pipeline: six register stages (4 lane, 1 merge, 1 output); the accepting edge
// loads the first.
// Stall: when rsp_out.ready is low, the output buffer fills; once its skid entry
// is taken, req_in.ready drops and the whole pipe holds. req_in.ready is a
// register output and does not depend on rsp_out.ready in the same cycle.
// Reset (synchronous, active high) empties the pipe and the buffer; no
// configuration and no stored state beyond the items in flight.
// Depends on ddd_pkg, ddd_if, ddd_lane, ddd_merge, ddd_out_buf.
`default_nettype none
`include "date_difference_days_core_macros.svh"

module date_difference_days_core import ddd_pkg::*; #(
   parameter int YEAR_BITS = YEAR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ddd_req_if.sink    req_in,
   ddd_rsp_if.source  rsp_out
);

   localparam int LANE_STAGES = 4;

   logic                 advance;
   logic                 accept;
   logic [LANE_STAGES-1:0] lane_valid_in, lane_valid_ff;
   logic                 merge_valid_ff;
   logic [YEAR_BITS+8:0] first_num, second_num;
   logic                 first_ok, second_ok;
   rsp_item_type         merge_item, buf_item;
   logic                 buf_room, buf_valid;

   // whole pipe moves whenever the output buffer has a free entry
   assign advance      = buf_room;
   assign req_in.ready = advance;
   assign accept       = advance && req_in.valid;

   // item valid bits alongside the lane stages
   assign lane_valid_in = {lane_valid_ff[LANE_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff  <= '0;
         merge_valid_ff <= 1'b0;
      end else if (advance) begin
         lane_valid_ff  <= lane_valid_in;
         merge_valid_ff <= lane_valid_ff[LANE_STAGES-1];
      end
   end

   ddd_lane #(.YEAR_BITS(YEAR_BITS)) u_lane_first (
      .clock   (clock),
      .advance (advance),
      .day     (req_in.first_day),
      .month   (req_in.first_month),
      .year    (req_in.first_year),
      .day_num (first_num),
      .date_ok (first_ok)
   );

   ddd_lane #(.YEAR_BITS(YEAR_BITS)) u_lane_second (
      .clock   (clock),
      .advance (advance),
      .day     (req_in.second_day),
      .month   (req_in.second_month),
      .year    (req_in.second_year),
      .day_num (second_num),
      .date_ok (second_ok)
   );

   ddd_merge #(.YEAR_BITS(YEAR_BITS)) u_merge (
      .clock      (clock),
      .advance    (advance),
      .first_num  (first_num),
      .first_ok   (first_ok),
      .second_num (second_num),
      .second_ok  (second_ok),
      .item       (merge_item)
   );

   ddd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && merge_valid_ff),
      .push_item (merge_item),
      .room      (buf_room),
      .out_valid (buf_valid),
      .out_ready (rsp_out.ready),
      .out_item  (buf_item)
   );

   assign rsp_out.valid   = buf_valid;
   assign rsp_out.status  = buf_item.status;
   assign rsp_out.day_gap = buf_item.day_gap;

   // an invalid date never carries a gap
   `DDD_ASSERT_NOW(a_bad_date_no_gap, clock, reset, rsp_out.valid && (rsp_out.status != STATUS_OK), rsp_out.day_gap == '0)
   // a full buffer always presents an item
   `DDD_ASSERT_NOW(a_full_has_output, clock, reset, !buf_room, buf_valid)
   // after an item leaves the merge stage, rsp_out.valid is high on the next cycle
   `DDD_ASSERT_NEXT(a_push_shows, clock, reset, advance && merge_valid_ff, rsp_out.valid)

endmodule

`default_nettype wire

FILE: sim/date_difference_days_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for date_difference_days_core: two-date requests in,
// status and day-gap items out, each checked against an in-bench calendar model.
// Depends on ddd_pkg, ddd_if and the core RTL.

module date_difference_days_core_test;
   import ddd_pkg::*;

   localparam int YEAR_W   = YEAR_BITS_DEF;
   localparam int YEAR_TOP = (1 << YEAR_W) - 1;
   localparam int SETTLE   = 20;    // cycles to wait after the last item
   localparam int HOLD_AT  = 500;   // result count that starts the long receiver hold-off
   localparam int HOLD_LEN = 300;

   // month lengths and days before each month, common year; index 0 unused
   localparam int unsigned MONTH_LENGTH[0:12] =
      '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned DAYS_BEFORE[0:12] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct {
      bit [DAY_W-1:0]   first_day;
      bit [MONTH_W-1:0] first_month;
      bit [YEAR_W-1:0]  first_year;
      bit [DAY_W-1:0]   second_day;
      bit [MONTH_W-1:0] second_month;
      bit [YEAR_W-1:0]  second_year;
      bit               wait_for_drain;   // sender idles until all results are back
   } date_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddd_req_if #(.YEAR_BITS(YEAR_W)) date_req ();
   ddd_rsp_if                       gap_rsp ();

   date_difference_days_core #(.YEAR_BITS(YEAR_W)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (date_req),
      .rsp_out (gap_rsp)
   );

   always #5 clock = ~clock;

   date_pair_type queued_date_pairs[$];
   rsp_item_type  expected_gaps[$];
   int            error_count  = 0;
   int            gaps_checked = 0;
   bit            req_taken    = 1'b0;

   // ---------------------------------------------------------------
   // Calendar model
   // ---------------------------------------------------------------
   function automatic bit is_leap(int unsigned year);
      return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
   endfunction

   function automatic int unsigned month_days(int unsigned month, int unsigned year);
      if (month < 1 || month > 12) return 0;
      if (month == 2 && is_leap(year)) return 29;
      return MONTH_LENGTH[month];
   endfunction

   function automatic bit date_is_valid(int unsigned day, int unsigned month,
                                        int unsigned year);
      return year != 0 && month >= 1 && month <= 12 && day >= 1 &&
             day <= month_days(month, year);
   endfunction

   // serial day number, 1 for January 1 of year 1
   function automatic longint day_serial(int unsigned day, int unsigned month,
                                         int unsigned year);
      longint prior;
      longint serial;
      prior  = longint'(year) - 1;
      serial = prior * 365 + prior / 4 - prior / 100 + prior / 400;
      serial += DAYS_BEFORE[month];
      if (month > 2 && is_leap(year)) serial += 1;
      return serial + day;
   endfunction

   function automatic rsp_item_type predict_day_gap(date_pair_type pair);
      rsp_item_type gap_item;
      longint       first_serial;
      longint       second_serial;
      longint       span;
      gap_item.day_gap = '0;
      if (!date_is_valid(pair.first_day, pair.first_month, pair.first_year)) begin
         gap_item.status = STATUS_FIRST_BAD;
      end else if (!date_is_valid(pair.second_day, pair.second_month,
                                  pair.second_year)) begin
         gap_item.status = STATUS_SECOND_BAD;
      end else begin
         first_serial  = day_serial(pair.first_day, pair.first_month, pair.first_year);
         second_serial = day_serial(pair.second_day, pair.second_month, pair.second_year);
         span = (first_serial >= second_serial) ? first_serial - second_serial
                                                : second_serial - first_serial;
         gap_item.status  = STATUS_OK;
         gap_item.day_gap = (span > longint'(GAP_MAX)) ? GAP_MAX : span[GAP_W-1:0];
      end
      return gap_item;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_dates(int d1, int m1, int y1, int d2, int m2, int y2);
      date_pair_type pair;
      pair.first_day      = DAY_W'(d1);
      pair.first_month    = MONTH_W'(m1);
      pair.first_year     = YEAR_W'(y1);
      pair.second_day     = DAY_W'(d2);
      pair.second_month   = MONTH_W'(m2);
      pair.second_year    = YEAR_W'(y2);
      pair.wait_for_drain = 1'b0;
      queued_date_pairs.push_back(pair);
   endtask

   // leans on century and leap years, and on month ends
   function automatic void pick_valid_date(input int near_year, output bit [DAY_W-1:0] day,
                                           output bit [MONTH_W-1:0] month,
                                           output bit [YEAR_W-1:0] year);
      int unsigned y;
      int unsigned length;
      if (near_year > 0 && $urandom_range(0, 1) == 1) begin
         y = near_year + $urandom_range(0, 4);
         y = (y > 2) ? y - 2 : 1;
         if (y > YEAR_TOP) y = YEAR_TOP;
      end else begin
         case ($urandom_range(0, 3))
            0:       y = $urandom_range(1, YEAR_TOP);
            1:       y = 100 * $urandom_range(1, YEAR_TOP / 100);
            2:       y = 4 * $urandom_range(1, YEAR_TOP / 4);
            default: y = $urandom_range(1, 3000);
         endcase
      end
      month  = MONTH_W'($urandom_range(1, 12));
      length = month_days(month, y);
      day    = DAY_W'(($urandom_range(0, 3) == 0) ? length : $urandom_range(1, length));
      year   = YEAR_W'(y);
   endfunction

   function automatic date_pair_type random_date_pair();
      date_pair_type pair;
      pick_valid_date(0, pair.first_day, pair.first_month, pair.first_year);
      pick_valid_date(int'(pair.first_year), pair.second_day, pair.second_month,
                      pair.second_year);
      pair.wait_for_drain = 1'b0;
      case ($urandom_range(0, 19))
         // raw noise over the whole field ranges
         0, 1: begin
            pair.first_day    = DAY_W'($urandom);
            pair.first_month  = MONTH_W'($urandom);
            pair.first_year   = YEAR_W'($urandom);
            pair.second_day   = DAY_W'($urandom);
            pair.second_month = MONTH_W'($urandom);
            pair.second_year  = YEAR_W'($urandom);
         end
         // one past the month end, or day zero
         2: pair.first_day  = DAY_W'(($urandom_range(0, 1) == 1 && pair.first_day < 31) ?
                              month_days(pair.first_month, pair.first_year) + 1 : 0);
         3: pair.second_day = DAY_W'(($urandom_range(0, 1) == 1 && pair.second_day < 31) ?
                              month_days(pair.second_month, pair.second_year) + 1 : 0);
         // month out of range or year zero
         4: pair.first_month  = MONTH_W'(($urandom_range(0, 1) == 1) ? 0 :
                                         $urandom_range(13, 15));
         5: pair.second_year  = '0;
         default: ;
      endcase
      return pair;
   endfunction

   task automatic drive_pair(date_pair_type pair, bit offer);
      date_req.valid        <= offer;
      date_req.first_day    <= pair.first_day;
      date_req.first_month  <= pair.first_month;
      date_req.first_year   <= pair.first_year;
      date_req.second_day   <= pair.second_day;
      date_req.second_month <= pair.second_month;
      date_req.second_year  <= pair.second_year;
   endtask

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps, changes on the falling edge
   // ---------------------------------------------------------------
   int burst_left = 8;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         drive_pair(random_date_pair(), 1'b0);
      end else if (date_req.valid && !req_taken) begin
         // item still on offer, hold it
      end else if (gap_left > 0) begin
         gap_left--;
         drive_pair(random_date_pair(), 1'b0);
      end else if (queued_date_pairs.size() == 0 ||
                   (queued_date_pairs[0].wait_for_drain && expected_gaps.size() != 0)) begin
         drive_pair(random_date_pair(), 1'b0);
      end else begin
         drive_pair(queued_date_pairs[0], 1'b1);
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // ---------------------------------------------------------------
   // Result receiver: stall modes that change now and then, plus one long hold-off
   // ---------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 100;
   int stall_step = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         gap_rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         gap_rsp.ready <= 1'b0;
      end else if (!hold_done && gaps_checked >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN - 1;
         gap_rsp.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
         end
         mode_left--;
         stall_step++;
         case (stall_mode)
            0:       gap_rsp.ready <= 1'b1;
            1:       gap_rsp.ready <= 1'($urandom_range(0, 1));
            2:       gap_rsp.ready <= ($urandom_range(0, 3) == 0);
            default: gap_rsp.ready <= (stall_step % 8) < 5;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check results, then record accepted requests
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      date_pair_type pair;
      req_taken = !reset && date_req.valid && date_req.ready;
      if (!reset && gap_rsp.valid && gap_rsp.ready) begin
         gaps_checked++;
         if (expected_gaps.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result status=%0d day_gap=%0d", $realtime,
                        gap_rsp.status, gap_rsp.day_gap);
         end else begin
            want = expected_gaps.pop_front();
            if (gap_rsp.status !== want.status || gap_rsp.day_gap !== want.day_gap) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result mismatch: expected status=%0d day_gap=%0d, got status=%0d day_gap=%0d",
                           $realtime, want.status, want.day_gap, gap_rsp.status,
                           gap_rsp.day_gap);
            end
         end
      end
      if (req_taken) begin
         pair = queued_date_pairs.pop_front();
         expected_gaps.push_back(predict_day_gap(pair));
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      date_pair_type pair;
      date_req.valid        = 1'b0;
      date_req.first_day    = '0;
      date_req.first_month  = '0;
      date_req.first_year   = '0;
      date_req.second_day   = '0;
      date_req.second_month = '0;
      date_req.second_year  = '0;
      gap_rsp.ready         = 1'b0;

      // directed: field extremes, leap rules, every status
      queue_dates(1, 1, 1, 1, 1, 1);                      // earliest date, zero gap
      queue_dates(31, 12, YEAR_TOP, 1, 1, 1);             // widest gap
      queue_dates(1, 1, 1, 31, 12, YEAR_TOP);             // same, order swapped
      queue_dates(29, 2, 2000, 28, 2, 1900);              // leap by 400, common century
      queue_dates(29, 2, 1900, 1, 1, 2000);               // century not leap: first bad
      queue_dates(1, 3, 2023, 29, 2, 2024);               // leap by 4
      queue_dates(1, 3, 2023, 29, 2, 2023);               // common year Feb 29: second bad
      queue_dates(1, 3, 2024, 28, 2, 2024);               // March after leap day
      queue_dates(0, 5, 2010, 1, 5, 2010);                // day zero
      queue_dates(15, 0, 2010, 1, 5, 2010);               // month zero
      queue_dates(15, 5, 2010, 1, 13, 2010);              // month 13
      queue_dates(15, 15, 2010, 1, 5, 2010);              // month field all ones
      queue_dates(15, 5, 0, 1, 5, 2010);                  // year zero, first
      queue_dates(15, 5, 2010, 1, 5, 0);                  // year zero, second
      queue_dates(31, 4, 2010, 31, 6, 2010);              // both bad: first wins
      queue_dates(31, 4, 2010, 30, 4, 2010);              // April 31
      queue_dates(31, 12, 1999, 1, 1, 2000);              // December accepted
      queue_dates(31, 15, YEAR_TOP, 31, 15, YEAR_TOP);    // all ones
      queue_dates(29, 2, 1600, 29, 2, YEAR_TOP - 383);    // leap centuries
      queue_dates(31, 1, 1, 31, 12, 1);                   // month ends, year 1

      // random: mostly well-formed dates, some noise and broken dates
      repeat (1280) begin
         pair = random_date_pair();
         // pause the sender twice until the block has drained
         if (queued_date_pairs.size() == 400 || queued_date_pairs.size() == 900)
            pair.wait_for_drain = 1'b1;
         queued_date_pairs.push_back(pair);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_date_pairs.size() != 0 || expected_gaps.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
